// ===== hw/rtl/fuzzy_substring_matcher_unit_assert.svh =====
// Assertion macros for the fuzzy substring matcher.
// Included by the top-level module, which checks its own logic; needs clk and arst_n in scope.
`ifndef FUZZY_SUBSTRING_MATCHER_UNIT_ASSERT_SVH
`define FUZZY_SUBSTRING_MATCHER_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define FZM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FZM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fzm_pkg.sv =====
// Shared types, constants and helpers of the fuzzy substring matcher.
// No dependencies; used by the cell and the top level.
package fzm_pkg;

	localparam int PATTERN_LEN_DEF    = 16;
	localparam int DISTANCE_LIMIT_DEF = 15;
	localparam int CFG_INDEX_W        = 3;
	localparam int CFG_DATA_W         = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PAT_LOW  = 3'd0,
		REG_PAT_HIGH = 3'd1,
		REG_PAT_LEN  = 3'd2,
		REG_MAX_DIST = 3'd3,
		REG_CASE     = 3'd4
	} fzm_reg_t;

	// Broadcast controls from the top level to every cell.
	typedef struct packed {
		logic step;     // a character transfer happens this cycle
		logic clear;    // that character ends the name
		logic fuzzy;    // distance mode
		logic exact;    // substring mode
		logic fold_on;  // substring mode folds letters
	} fzm_ctl_t;

	function automatic logic [7:0] fold_char(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/fzm_if.sv =====
// Valid/ready channel interfaces for name characters and match results.
// Depends on nothing; used by the top level ports.
interface fzm_name_if;
	logic       valid;
	logic       ready;
	logic [7:0] name_char;
	logic       last_of_name;
	modport source (output valid, name_char, last_of_name, input ready);
	modport sink   (input valid, name_char, last_of_name, output ready);
endinterface

interface fzm_result_if;
	logic valid;
	logic ready;
	logic name_matches;
	modport source (output valid, name_matches, input ready);
	modport sink   (input valid, name_matches, output ready);
endinterface

// ===== hw/rtl/fuzzy_substring_matcher_unit.sv =====
// Fuzzy substring matcher: tests streamed names against a configured pattern
// of up to PATTERN_LEN characters, one name character per transfer, one
// transfer per cycle. Each character advances all attempts at once through a
// row of PATTERN_LEN cells, one per pattern position; the verdict for a name
// passes the final-check stage and is offered from the output register; input
// stalls only while both are full and the result is not taken. Configuration
// must be written while no name is in flight; the block does not enforce it.
module fuzzy_substring_matcher_unit #(
	parameter int PATTERN_LEN    = fzm_pkg::PATTERN_LEN_DEF,
	parameter int DISTANCE_LIMIT = fzm_pkg::DISTANCE_LIMIT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fzm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fzm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	fzm_name_if.sink                       items,
	fzm_result_if.source                   results
);
	import fzm_pkg::*;

	localparam int LW = $clog2(PATTERN_LEN + 1);
	localparam int DW = $clog2(DISTANCE_LIMIT + 1);
	localparam int TW = DISTANCE_LIMIT + 1;

	logic [127:0] pat_q;
	logic [4:0]   len_q;
	logic [3:0]   dist_q;
	logic         case_q;
	logic [7:0]   prev_q, char_s1;
	logic         found_q, found_s1, valid_s1, out_valid_q, matches_q;

	logic [LW-1:0]          eff_len;
	logic [DW-1:0]          dist_c;
	logic [PATTERN_LEN-1:0] in_pat, found_run, end_ok;
	logic                   accept, s1_go, found_now, end_any;
	fzm_ctl_t               ctl;

	logic [TW-1:0] pend [PATTERN_LEN+1];
	logic [TW-1:0] hit0 [PATTERN_LEN+1];
	logic [TW-1:0] hit1 [PATTERN_LEN+1];
	logic [TW-1:0] endp [PATTERN_LEN+1];
	logic          ex   [PATTERN_LEN+1];

	// Pattern ends at the length limit or at its first zero byte.
	always_comb begin
		logic run;
		run     = 1'b1;
		eff_len = '0;
		for (int i = 0; i < PATTERN_LEN; i++) begin
			run = run && (pat_q[i*8 +: 8] != 8'h00) && (i < int'(len_q));
			in_pat[i] = run;
			if (run) begin
				eff_len = LW'(i + 1);
			end
		end
		dist_c = (int'(dist_q) > DISTANCE_LIMIT) ? DW'(DISTANCE_LIMIT) : DW'(dist_q);
	end

	assign items.ready = !(valid_s1 && out_valid_q && !results.ready);
	assign accept      = items.valid && items.ready;
	assign s1_go       = valid_s1 && (!out_valid_q || results.ready);

	always_comb begin
		ctl.step    = accept;
		ctl.clear   = accept && items.last_of_name;
		ctl.fuzzy   = (eff_len != '0) && (dist_c != '0);
		ctl.exact   = (eff_len != '0) && (dist_c == '0);
		ctl.fold_on = !case_q;
	end

	assign pend[0] = '0;
	assign hit0[0] = '0;
	assign hit1[0] = '0;
	assign endp[0] = '0;
	assign ex[0]   = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < PATTERN_LEN; gi++) begin : g_cell
			logic nxt_in;
			if (gi + 1 < PATTERN_LEN) begin : g_mid
				assign nxt_in = in_pat[gi+1];
			end else begin : g_end
				assign nxt_in = 1'b0;
			end
			fzm_cell #(
				.IDX(gi),
				.PATTERN_LEN(PATTERN_LEN),
				.DISTANCE_LIMIT(DISTANCE_LIMIT)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.pat_char(pat_q[gi*8 +: 8]),
				.cur_char(items.name_char),
				.prev_char(prev_q),
				.end_char(char_s1),
				.eff_len(eff_len),
				.max_skip(dist_c),
				.in_pat(in_pat[gi]),
				.next_in_pat(nxt_in),
				.pend_in(pend[gi]),
				.pend_out(pend[gi+1]),
				.hit0_in(hit0[gi]),
				.hit0_out(hit0[gi+1]),
				.hit1_in(hit1[gi]),
				.hit1_out(hit1[gi+1]),
				.ex_in(ex[gi]),
				.ex_out(ex[gi+1]),
				.endp_in(endp[gi]),
				.endp_out(endp[gi+1]),
				.found_run(found_run[gi]),
				.end_ok(end_ok[gi])
			);
		end
	endgenerate

	// Tokens that run off the last cell have passed every pattern position.
	assign found_now = found_q || (|found_run) || (ctl.fuzzy && (|pend[PATTERN_LEN]))
		|| (eff_len == '0);
	assign end_any = (|end_ok) || (|endp[PATTERN_LEN]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			len_q  <= '0;
			dist_q <= '0;
			case_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_LOW:  pat_q[63:0]   <= cfg_wdata;
				REG_PAT_HIGH: pat_q[127:64] <= cfg_wdata;
				REG_PAT_LEN:  len_q  <= cfg_wdata[4:0];
				REG_MAX_DIST: dist_q <= cfg_wdata[3:0];
				REG_CASE:     case_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			found_q     <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				prev_q  <= items.last_of_name ? 8'h00 : items.name_char;
				found_q <= items.last_of_name ? 1'b0 : found_now;
			end
			if (ctl.clear) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			char_s1  <= items.name_char;
			found_s1 <= found_now;
		end
		if (s1_go) begin
			matches_q <= found_s1 || (ctl.fuzzy && end_any);
		end
	end

	assign results.valid        = out_valid_q;
	assign results.name_matches = matches_q;

	`include "fuzzy_substring_matcher_unit_assert.svh"

	`FZM_ASSERT(a_stall_only_full, !items.ready |-> (valid_s1 && out_valid_q), "stall without full stages")
	`FZM_ASSERT_NEXT(a_clear_found, accept && items.last_of_name, !found_q, "match flag not cleared")
	`FZM_ASSERT_NEXT(a_s1_to_out, s1_go, out_valid_q, "result lost between stages")

endmodule

// ===== hw/rtl/fzm_cell.sv =====
// One pattern position of the matcher: holds the attempts waiting at this position.
// Depends on fzm_pkg; instantiated in a row by fuzzy_substring_matcher_unit.
module fzm_cell #(
	parameter int IDX            = 0,
	parameter int PATTERN_LEN    = fzm_pkg::PATTERN_LEN_DEF,
	parameter int DISTANCE_LIMIT = fzm_pkg::DISTANCE_LIMIT_DEF,
	localparam int LW = $clog2(PATTERN_LEN + 1),
	localparam int DW = $clog2(DISTANCE_LIMIT + 1),
	localparam int TW = DISTANCE_LIMIT + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fzm_pkg::fzm_ctl_t ctl,
	input  logic [7:0]        pat_char,
	input  logic [7:0]        cur_char,
	input  logic [7:0]        prev_char,
	input  logic [7:0]        end_char,
	input  logic [LW-1:0]     eff_len,
	input  logic [DW-1:0]     max_skip,
	input  logic              in_pat,
	input  logic              next_in_pat,
	input  logic [TW-1:0]     pend_in,
	output logic [TW-1:0]     pend_out,
	input  logic [TW-1:0]     hit0_in,
	output logic [TW-1:0]     hit0_out,
	input  logic [TW-1:0]     hit1_in,
	output logic [TW-1:0]     hit1_out,
	input  logic              ex_in,
	output logic              ex_out,
	input  logic [TW-1:0]     endp_in,
	output logic [TW-1:0]     endp_out,
	output logic              found_run,
	output logic              end_ok
);
	import fzm_pkg::*;

	logic [TW-1:0] att_next_q, att_after_q;
	logic [TW-1:0] att_next_s1, att_after_s1;
	logic [TW-1:0] att_next_nxt, att_after_nxt;
	logic [TW-1:0] tok, tok_end, start_vec, mask_a, mask_b;
	logic [7:0]    cc, pc;
	logic          mx, my;

	always_comb begin
		for (int d = 0; d < TW; d++) begin
			mask_a[d] = (d + IDX + 1) >= int'(eff_len);
			mask_b[d] = (d + IDX) >= int'(eff_len);
		end
	end

	// A new attempt starts only at the first position; in distance mode it is always case-folded.
	generate
		if (IDX == 0) begin : g_start
			assign start_vec = (fold_char(cur_char) == fold_char(pat_char)) ?
				(TW'(1) << max_skip) : '0;
		end else begin : g_nostart
			assign start_vec = '0;
		end
	endgenerate

	always_comb begin
		tok       = att_next_q | pend_in;
		mx        = (prev_char == pat_char);
		my        = (cur_char == pat_char);
		cc        = ctl.fold_on ? fold_char(cur_char) : cur_char;
		pc        = ctl.fold_on ? fold_char(pat_char) : pat_char;
		pend_out  = '0;
		hit0_out  = '0;
		hit1_out  = '0;
		ex_out    = 1'b0;
		found_run = 1'b0;
		att_next_nxt  = att_next_q;
		att_after_nxt = att_after_q;
		if (ctl.fuzzy) begin
			if (!in_pat) begin
				found_run = |tok;
			end else if (mx || my) begin
				if (!next_in_pat) begin
					found_run = |tok;
				end else if (mx) begin
					hit0_out = tok;
				end else begin
					hit1_out = tok;
				end
			end else begin
				// A miss spends one unit of distance and moves to the next position.
				pend_out = tok >> 1;
			end
			if (next_in_pat) begin
				hit1_out = hit1_out | start_vec;
			end else begin
				found_run = found_run | (|start_vec);
			end
			att_next_nxt  = hit0_in | att_after_q;
			att_after_nxt = hit1_in;
		end else if (ctl.exact) begin
			if (in_pat && (IDX == 0 || att_next_q[0]) && cc == pc) begin
				if (next_in_pat) begin
					ex_out = 1'b1;
				end else begin
					found_run = 1'b1;
				end
			end
			att_next_nxt  = TW'(ex_in);
			att_after_nxt = '0;
		end
	end

	// Final check on the snapshot taken with the last character of the name.
	always_comb begin
		tok_end  = att_next_s1 | endp_in;
		endp_out = '0;
		end_ok   = |(att_after_s1 & mask_b);
		if (!in_pat) begin
			end_ok = end_ok | (|tok_end);
		end else if (end_char == pat_char) begin
			end_ok = end_ok | (|(tok_end & mask_a));
		end else begin
			endp_out = tok_end >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_next_q  <= '0;
			att_after_q <= '0;
		end else if (ctl.clear) begin
			att_next_q  <= '0;
			att_after_q <= '0;
		end else if (ctl.step) begin
			att_next_q  <= att_next_nxt;
			att_after_q <= att_after_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			att_next_s1  <= att_next_nxt;
			att_after_s1 <= att_after_nxt;
		end
	end

endmodule
